/* hdl/mfr_pkg.sv */
`timescale 1ns / 1ps
package mfr_pkg;
    localparam int REG_WIDTH = 48;
    localparam int ACC_WIDTH = 140;
    localparam int QUO_WIDTH = 136;
    // Fraction bits of a coordinate; dot products and the tolerance registers
    // carry twice this many.
    localparam int FRAC_BITS = 16;

    localparam logic [2:0] OP_POINT     = 3'd0;
    localparam logic [2:0] OP_ANCHOR    = 3'd1;
    localparam logic [2:0] OP_NEIGHBOUR = 3'd2;
    localparam logic [2:0] OP_EDGE_A    = 3'd3;
    localparam logic [2:0] OP_EDGE_B    = 3'd4;
    localparam logic [2:0] OP_WING      = 3'd5;
    localparam logic [2:0] OP_INTERIOR  = 3'd6;
    localparam logic [2:0] OP_NOT_FOUND = 3'd7;

    localparam logic CFG_TOLERANCE = 1'b0;
    localparam logic CFG_MIN_EDGE  = 1'b1;

    localparam logic [REG_WIDTH-1:0] TOL_RESET     = 48'd4295;
    localparam logic [REG_WIDTH-1:0] MIN_EDGE_RESET = 48'd1;

    typedef struct packed {
        logic [2:0]         operation;
        logic signed [31:0] coord_x;
        logic signed [31:0] coord_y;
        logic signed [31:0] coord_z;
        logic               last;
    } in_word_t;

    typedef struct packed {
        logic [0:0]          index;
        logic [REG_WIDTH-1:0] data;
    } cfg_word_t;
endpackage

/* hdl/mfr_if.sv */
`timescale 1ns / 1ps
interface mfr_in_if import mfr_pkg::*; ();
    logic     valid;
    logic     ready;
    in_word_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface mfr_out_if;
    logic valid;
    logic ready;
    logic feasible;
    modport source (output valid, output feasible, input ready);
    modport sink (input valid, input feasible, output ready);
endinterface

interface mfr_cfg_if import mfr_pkg::*; ();
    logic      valid;
    logic      ready;
    cfg_word_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

/* hdl/mfr_divider.sv */
`timescale 1ns / 1ps
module mfr_divider import mfr_pkg::*; (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [QUO_WIDTH-1:0]        dividend,
    input  logic [QUO_WIDTH-1:0]        divisor,
    output logic                        done,
    output logic [QUO_WIDTH-1:0]        quotient
);
    // Restoring division, one quotient bit per cycle.
    localparam int CW = $clog2(QUO_WIDTH + 1);
    logic [QUO_WIDTH-1:0] quo_reg, quo_next;
    logic [QUO_WIDTH:0]   rem_reg, rem_next;
    logic [QUO_WIDTH-1:0] div_reg, div_next;
    logic [CW-1:0]        cnt_reg, cnt_next;
    logic                 busy_reg, busy_next, done_reg, done_next;
    logic [QUO_WIDTH:0]   shifted, diff;

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        shifted   = {rem_reg[QUO_WIDTH-1:0], quo_reg[QUO_WIDTH-1]};
        diff      = shifted - {1'b0, div_reg};
        if (start)
        begin
            quo_next  = dividend;
            rem_next  = '0;
            div_next  = divisor;
            cnt_next  = CW'(QUO_WIDTH);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!diff[QUO_WIDTH])
            begin
                rem_next = diff;
                quo_next = {quo_reg[QUO_WIDTH-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted;
                quo_next = {quo_reg[QUO_WIDTH-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        div_reg <= div_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;
endmodule

/* hdl/mesh_feature_feasible_region_test.sv */
`timescale 1ns / 1ps
// Channel   | Role | Word                                        | Accepted when
// ----------+------+---------------------------------------------+---------------------
// in_ch     | sink | operation, coord_x/y/z, last                | valid && ready
// out_ch    | src  | feasible (one word per item marked last)    | valid && ready
// cfg_ch    | sink | index (0 tolerance, 1 min_edge_sq_length)   | valid && ready
//
// Each word is processed by a sequencer around one shared signed multiplier of
// (COORD_WIDTH+2) by (COORD_WIDTH+2) bits, 34x34 by default.
// in_ch.ready stays low while a word is in work. Point, anchor, edge start, interior,
// not-found and skipped wing words need no product; a neighbour or edge end forms
// dot products; a wing adds a 136-step serial divide for the foot of the perpendicular.
// A word marked last holds in its final cycle while an earlier verdict still
// waits on out_ch. Reset clears the geometry state and the verdict to feasible.
module mesh_feature_feasible_region_test import mfr_pkg::*; #(
    parameter int COORD_WIDTH = 32
) (
    input  logic clk,
    input  logic rst_n,
    mfr_in_if.sink    in_ch,
    mfr_out_if.source out_ch,
    mfr_cfg_if.sink   cfg_ch
);
    localparam int DW = COORD_WIDTH + 2;      // difference width
    localparam int PW = 2 * DW;               // product width
    localparam int CH = DW - 1;               // magnitude chunk width

    localparam logic [3:0] S_IDLE = 4'd0, S_MUL = 4'd1, S_EVAL = 4'd2,
                           S_QMUL = 4'd3, S_DIV = 4'd5,
                           S_WAITD = 4'd6, S_FIN = 4'd7;

    logic [3:0] state_reg;
    logic [REG_WIDTH-1:0] tol_reg, min_reg;
    logic signed [COORD_WIDTH-1:0] qp_reg [3];
    logic signed [COORD_WIDTH-1:0] av_reg [3];
    logic signed [COORD_WIDTH:0]   ev_reg [3];
    logic signed [ACC_WIDTH-1:0]   len_reg;
    logic degen_reg, verdict_reg, out_valid_reg, out_feas_reg;
    in_word_t  word_reg;
    logic signed [COORD_WIDTH-1:0] c [3];

    // multiply schedule: step counter walks up to 9 products
    logic [3:0] step_reg;
    logic signed [ACC_WIDTH-1:0] acc0_reg, acc1_reg, acc2_reg;
    logic signed [DW-1:0] ma, mb;
    logic signed [PW-1:0] prod;
    logic [1:0] lane;
    logic [1:0] grp;

    // wing quotient: |dw|*|dp| built from four chunk products
    logic [ACC_WIDTH-1:0] aw, ap;
    logic [CH-1:0]        qa_chunk, qb_chunk;
    logic [QUO_WIDTH-1:0] qterm, qpart;
    logic [QUO_WIDTH-1:0] qprod_reg;
    logic                 qneg_reg;
    logic                 div_start, div_done;
    logic [QUO_WIDTH-1:0] div_q;

    logic signed [DW-1:0] da, db;

    logic signed [ACC_WIDTH-1:0] tol_s, q_s, s_val;

    assign in_ch.ready  = (state_reg == S_IDLE);
    assign cfg_ch.ready = 1'b1;
    assign out_ch.valid    = out_valid_reg;
    assign out_ch.feasible = out_feas_reg;

    always_comb
    begin
        c[0] = word_reg.coord_x[COORD_WIDTH-1:0];
        c[1] = word_reg.coord_y[COORD_WIDTH-1:0];
        c[2] = word_reg.coord_z[COORD_WIDTH-1:0];
    end

    // Operand selection per group/lane.
    // groups: 0 -> acc0, 1 -> acc1, 2 -> acc2 (three lanes each).
    always_comb
    begin
        if (step_reg inside {4'd0, 4'd1, 4'd2})
            grp = 2'd0;
        else if (step_reg inside {4'd3, 4'd4, 4'd5})
            grp = 2'd1;
        else
            grp = 2'd2;
        if (step_reg inside {4'd0, 4'd3, 4'd6})
            lane = 2'd0;
        else if (step_reg inside {4'd1, 4'd4, 4'd7})
            lane = 2'd1;
        else
            lane = 2'd2;
    end

    always_comb
    begin
        da = '0;
        db = '0;
        case (word_reg.operation)
            OP_NEIGHBOUR:
            begin
                da = DW'(qp_reg[lane]) - DW'(av_reg[lane]);
                db = DW'(av_reg[lane]) - DW'(c[lane]);
            end
            OP_EDGE_B:
            begin
                db = DW'(c[lane]) - DW'(av_reg[lane]);
                case (grp)
                    2'd0: da = DW'(qp_reg[lane]) - DW'(av_reg[lane]);
                    2'd1: da = DW'(qp_reg[lane]) - DW'(c[lane]);
                    default: da = db;
                endcase
            end
            OP_WING:
            begin
                case (grp)
                    2'd0:
                    begin
                        da = DW'(ev_reg[lane]);
                        db = DW'(c[lane]) - DW'(av_reg[lane]);
                    end
                    2'd1:
                    begin
                        da = DW'(ev_reg[lane]);
                        db = DW'(qp_reg[lane]) - DW'(av_reg[lane]);
                    end
                    default:
                    begin
                        da = DW'(c[lane]) - DW'(av_reg[lane]);
                        db = DW'(qp_reg[lane]) - DW'(av_reg[lane]);
                    end
                endcase
            end
            default:
            begin
                da = '0;
                db = '0;
            end
        endcase
    end

    // |dw| and |dp| stay below 2^(2*CH), so two chunks of CH bits hold each.
    // Step bit 1 picks the chunk of |dw|, step bit 0 the chunk of |dp|.
    always_comb
    begin
        aw = acc0_reg[ACC_WIDTH-1] ? ACC_WIDTH'(-acc0_reg) : ACC_WIDTH'(acc0_reg);
        ap = acc1_reg[ACC_WIDTH-1] ? ACC_WIDTH'(-acc1_reg) : ACC_WIDTH'(acc1_reg);
        qa_chunk = step_reg[1] ? aw[2*CH-1:CH] : aw[CH-1:0];
        qb_chunk = step_reg[0] ? ap[2*CH-1:CH] : ap[CH-1:0];
        if (state_reg == S_QMUL)
        begin
            ma = {1'b0, qa_chunk};
            mb = {1'b0, qb_chunk};
        end
        else
        begin
            ma = da;
            mb = db;
        end
    end

    // The one multiplier serves the dot terms and the quotient chunks; the
    // chunks enter with a zero sign bit, so their product is never negative.
    assign prod = ma * mb;

    always_comb
    begin
        qterm = QUO_WIDTH'(prod);
        case (step_reg[1:0])
            2'd0: qpart = qterm;
            2'd3: qpart = qterm << (2 * CH);
            default: qpart = qterm << CH;
        endcase
    end

    assign tol_s = ACC_WIDTH'({1'b0, tol_reg});
    assign q_s   = qneg_reg ? -ACC_WIDTH'(div_q) : ACC_WIDTH'(div_q);
    assign s_val = acc2_reg - q_s;

    mfr_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (qprod_reg),
        .divisor  (QUO_WIDTH'(len_reg)),
        .done     (div_done),
        .quotient (div_q)
    );

    assign div_start = (state_reg == S_DIV);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            tol_reg       <= TOL_RESET;
            min_reg       <= MIN_EDGE_RESET;
            degen_reg     <= 1'b0;
            verdict_reg   <= 1'b1;
            out_valid_reg <= 1'b0;
            out_feas_reg  <= 1'b0;
            step_reg      <= '0;
            len_reg       <= '0;
            for (int i = 0; i < 3; i++)
            begin
                qp_reg[i] <= '0;
                av_reg[i] <= '0;
                ev_reg[i] <= '0;
            end
        end
        else
        begin
            if (cfg_ch.valid && cfg_ch.ready)
            begin
                if (cfg_ch.data.index == CFG_TOLERANCE)
                    tol_reg <= cfg_ch.data.data;
                else
                    min_reg <= cfg_ch.data.data;
            end
            if (out_ch.valid && out_ch.ready)
                out_valid_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (in_ch.valid && in_ch.ready)
                    begin
                        word_reg <= in_ch.data;
                        step_reg <= '0;
                        acc0_reg <= '0;
                        acc1_reg <= '0;
                        acc2_reg <= '0;
                        state_reg <= S_MUL;
                    end
                end
                S_MUL:
                begin
                    case (word_reg.operation)
                        OP_POINT:
                        begin
                            qp_reg <= c;
                            state_reg <= S_FIN;
                        end
                        OP_ANCHOR:
                        begin
                            av_reg <= c;
                            state_reg <= S_FIN;
                        end
                        OP_EDGE_A:
                        begin
                            av_reg <= c;
                            degen_reg <= 1'b1;
                            state_reg <= S_FIN;
                        end
                        OP_INTERIOR:
                        begin
                            verdict_reg <= 1'b1;
                            state_reg <= S_FIN;
                        end
                        OP_NOT_FOUND:
                        begin
                            verdict_reg <= 1'b0;
                            state_reg <= S_FIN;
                        end
                        OP_WING:
                        begin
                            if (degen_reg || len_reg == '0)
                                state_reg <= S_FIN;
                            else
                            begin
                                case (grp)
                                    2'd0: acc0_reg <= acc0_reg + ACC_WIDTH'(prod);
                                    2'd1: acc1_reg <= acc1_reg + ACC_WIDTH'(prod);
                                    default: acc2_reg <= acc2_reg + ACC_WIDTH'(prod);
                                endcase
                                step_reg <= step_reg + 1'b1;
                                if (step_reg == 4'd8)
                                    state_reg <= S_EVAL;
                            end
                        end
                        default:
                        begin
                            case (grp)
                                2'd0: acc0_reg <= acc0_reg + ACC_WIDTH'(prod);
                                2'd1: acc1_reg <= acc1_reg + ACC_WIDTH'(prod);
                                default: acc2_reg <= acc2_reg + ACC_WIDTH'(prod);
                            endcase
                            step_reg <= step_reg + 1'b1;
                            if ((word_reg.operation == OP_NEIGHBOUR && step_reg == 4'd2)
                                || step_reg == 4'd8)
                                state_reg <= S_EVAL;
                        end
                    endcase
                end
                S_EVAL:
                begin
                    case (word_reg.operation)
                        OP_NEIGHBOUR:
                        begin
                            if (acc0_reg < -tol_s)
                                verdict_reg <= 1'b0;
                            state_reg <= S_FIN;
                        end
                        OP_EDGE_B:
                        begin
                            for (int i = 0; i < 3; i++)
                                ev_reg[i] <= (COORD_WIDTH+1)'(c[i]) -
                                             (COORD_WIDTH+1)'(av_reg[i]);
                            len_reg <= acc2_reg;
                            if (acc0_reg < -tol_s || acc1_reg > tol_s ||
                                acc2_reg == '0 ||
                                acc2_reg < ACC_WIDTH'({1'b0, min_reg}))
                                verdict_reg <= 1'b0;
                            degen_reg <= (acc2_reg == '0) ||
                                         (acc2_reg < ACC_WIDTH'({1'b0, min_reg}));
                            state_reg <= S_FIN;
                        end
                        default:
                        begin
                            qneg_reg   <= acc0_reg[ACC_WIDTH-1] ^ acc1_reg[ACC_WIDTH-1];
                            qprod_reg  <= '0;
                            step_reg   <= '0;
                            state_reg  <= S_QMUL;
                        end
                    endcase
                end
                S_QMUL:
                begin
                    // Four chunk products, each added at its own weight.
                    qprod_reg <= qprod_reg + qpart;
                    step_reg  <= step_reg + 1'b1;
                    if (step_reg == 4'd3)
                        state_reg <= S_DIV;
                end
                S_DIV:
                    state_reg <= S_WAITD;
                S_WAITD:
                begin
                    if (div_done)
                    begin
                        if (s_val > tol_s)
                            verdict_reg <= 1'b0;
                        state_reg <= S_FIN;
                    end
                end
                S_FIN:
                begin
                    // A closing word waits here until the previous verdict
                    // has left the output register.
                    if (word_reg.last)
                    begin
                        if (!out_valid_reg)
                        begin
                            out_valid_reg <= 1'b1;
                            out_feas_reg  <= verdict_reg;
                            verdict_reg   <= 1'b1;
                            state_reg     <= S_IDLE;
                        end
                    end
                    else
                        state_reg <= S_IDLE;
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end
endmodule

/* hdl/mfr_checker.sv */
`timescale 1ns / 1ps
module mfr_checker (
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready,
    input logic out_feasible
);
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_feasible))
        else $error("result dropped while stalled");
    a_quiet_in_reset: assert property (@(posedge clk)
        !rst_n |-> !out_valid)
        else $error("result offered during reset");
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("ready stayed high after accept");
endmodule

bind mesh_feature_feasible_region_test mfr_checker u_chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_ch.valid),
    .in_ready     (in_ch.ready),
    .out_valid    (out_ch.valid),
    .out_ready    (out_ch.ready),
    .out_feasible (out_ch.feasible)
);
